@@ src/nsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest center search package
// Shared widths, command codes, the query token that travels along the cell
// chain, and the best-candidate merge used by every cell and by the chain tail.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int NUM_CELLS = 64;   // table capacity, one cell per center
    localparam int SLOT_W    = 6;    // table index width
    localparam int COORD_W   = 16;   // signed coordinate width
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;      // one squared difference
    localparam int DIST2_W   = SQ_W + 1;         // sum of two squares
    localparam int DIST_W    = 17;               // integer root of DIST2_W bits
    localparam int COUNT_W   = 7;                // centers_in_use register
    localparam int ROOT_W    = DIST2_W + 1;      // working root in the iteration
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [DIST_W-1:0] DIST_NONE = '1;

    // Query token: the query point, the best center so far, and the candidate
    // that the previous cell computed but has not yet compared.
    typedef struct packed {
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        logic               have;
        logic [DIST2_W-1:0] best_d2;
        logic [SLOT_W-1:0]  best_idx;
        logic [COORD_W-1:0] best_x;
        logic [COORD_W-1:0] best_y;
        logic               cand_valid;
        logic [DIST2_W-1:0] cand_d2;
        logic [SLOT_W-1:0]  cand_idx;
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
    } t_token;

    // Fold the pending candidate into the best. Strict compare keeps the
    // lower index on a tie.
    function automatic t_token nsc_merge(input t_token t);
        t_token r;
        r = t;
        if (t.cand_valid && (!t.have || (t.cand_d2 < t.best_d2))) begin
            r.have     = 1'b1;
            r.best_d2  = t.cand_d2;
            r.best_idx = t.cand_idx;
            r.best_x   = t.cand_x;
            r.best_y   = t.cand_y;
        end
        r.cand_valid = 1'b0;
        return r;
    endfunction

endpackage

@@ src/nsc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest center search cell
// Holds one center, folds the candidate from its left neighbor into the best,
// and computes its own squared distance to the passing query point.
// ----------------------------------------------------------------------------
module nsc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nsc_pkg::SLOT_W-1:0]    i_index,
    input  logic [nsc_pkg::COUNT_W-1:0]   i_count,
    input  logic                          i_load,
    input  logic [nsc_pkg::COORD_W-1:0]   i_load_x,
    input  logic [nsc_pkg::COORD_W-1:0]   i_load_y,
    input  logic                          i_valid,
    input  nsc_pkg::t_token               i_token,
    output logic                          o_valid,
    output nsc_pkg::t_token               o_token
);
    import nsc_pkg::*;

    logic [COORD_W-1:0]       r_cx;
    logic [COORD_W-1:0]       r_cy;
    logic                     r_valid;
    t_token                   r_token;
    t_token                   n_token;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [2*DIFF_W-1:0] w_sqx;
    logic signed [2*DIFF_W-1:0] w_sqy;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx <= i_load_x;
            r_cy <= i_load_y;
        end
    end

    assign w_dx  = $signed({r_cx[COORD_W-1], r_cx}) -
                   $signed({i_token.qx[COORD_W-1], i_token.qx});
    assign w_dy  = $signed({r_cy[COORD_W-1], r_cy}) -
                   $signed({i_token.qy[COORD_W-1], i_token.qy});
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    always_comb begin
        n_token            = nsc_merge(i_token);
        n_token.cand_valid = ({1'b0, i_index} < i_count);
        n_token.cand_d2    = {1'b0, w_sqx[SQ_W-1:0]} + {1'b0, w_sqy[SQ_W-1:0]};
        n_token.cand_idx   = i_index;
        n_token.cand_x     = r_cx;
        n_token.cand_y     = r_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_token <= n_token;
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

@@ src/nsc_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest center search integer square root
// Bit-pair restoring square root, one result bit per cycle, rounded down.
// ----------------------------------------------------------------------------
module nsc_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nsc_pkg::DIST2_W-1:0]   i_value,
    output logic                          o_done,
    output logic [nsc_pkg::DIST_W-1:0]    o_root
);
    import nsc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIST2_W-1:0]   r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [DIST2_W-1:0]   r_bit;
    logic [ROOT_W-1:0]    w_trial;
    logic                 w_take;

    assign w_trial = r_root + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_rem} >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_root <= '0;
            r_bit  <= {1'b1, {(DIST2_W-1){1'b0}}};
        end else if (r_busy) begin
            if (w_take) begin
                r_rem  <= r_rem - w_trial[DIST2_W-1:0];
                r_root <= (r_root >> 1) + {1'b0, r_bit};
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[DIST_W-1:0];

endmodule

@@ src/nearest_center_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest center search
// Table of 2-D centers held in a chain of cells; a query token walks the
// chain and returns the nearest center and the floor of its distance.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  s_axis   | in        | tuser: command; tdata: center_slot, point_x, point_y
//  m_axis   | out       | tuser: found;  tdata: nearest_slot, nearest_x,
//           |           |        nearest_y, distance
//  cfg      | in        | centers_in_use (7 bits)
//
// In a load the addressed cell captures the center at the transfer edge,
// and the next item is taken in the following cycle.
// A query holds off all new items until the control is back in idle. Its
// token crosses the 64 cells, the final compare settling behind the last
// of them; then the square root iterates, its done flag is registered, and
// the output register is loaded with the result, which is then valid, once
// that register is free or being taken; then the control returns to idle.
// Reset clears the control state and centers_in_use; the center table is
// not cleared and holds whatever was loaded. A stalled result waits in the
// output register, and the block takes new items while it waits.
// ----------------------------------------------------------------------------
module nearest_center_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Query and load items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [nsc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // center_slot, point_x, point_y
    input  logic                             s_axis_tuser,  // command
    // Results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [nsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // nearest_slot, nearest_x,
                                                            // nearest_y, distance
    output logic                             m_axis_tuser,  // found
    // Configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nsc_pkg::COUNT_W-1:0]      i_cfg_data
);
    import nsc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_count;

    // Input fields
    logic                 w_cmd;
    logic [SLOT_W-1:0]    w_slot;
    logic [COORD_W-1:0]   w_px;
    logic [COORD_W-1:0]   w_py;
    logic                 w_in_xfer;
    logic                 w_out_xfer;

    // Cell chain
    logic                 w_valid [NUM_CELLS+1];
    t_token               w_token [NUM_CELLS+1];
    t_token               w_final;

    // Result holding and output registers
    logic                 r_res_have;
    logic [SLOT_W-1:0]    r_res_idx;
    logic [COORD_W-1:0]   r_res_x;
    logic [COORD_W-1:0]   r_res_y;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                 w_root_start;
    logic                 w_root_done;
    logic [DIST_W-1:0]    w_root;
    logic                 w_out_load;
    logic [NUM_CELLS-1:0] w_valid_vec;

    assign w_cmd  = s_axis_tuser;
    assign w_slot = s_axis_tdata[SLOT_W-1:0];
    assign w_px   = s_axis_tdata[SLOT_W +: COORD_W];
    assign w_py   = s_axis_tdata[SLOT_W+COORD_W +: COORD_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer    = r_out_valid && m_axis_tready;

    // The register always accepts a write; software writes it only while no
    // query is in flight, and the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // A query enters the chain as a token with no best and no candidate yet.
    always_comb begin
        w_token[0]            = '0;
        w_token[0].qx         = w_px;
        w_token[0].qy         = w_py;
        w_valid[0]            = w_in_xfer && (w_cmd == CMD_QUERY);
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        nsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (SLOT_W'(g)),
            .i_count  (r_count),
            .i_load   (w_in_xfer && (w_cmd == CMD_LOAD) && (w_slot == SLOT_W'(g))),
            .i_load_x (w_px),
            .i_load_y (w_py),
            .i_valid  (w_valid[g]),
            .i_token  (w_token[g]),
            .o_valid  (w_valid[g+1]),
            .o_token  (w_token[g+1])
        );
        assign w_valid_vec[g] = w_valid[g+1];
    end

    // The last cell's candidate still needs its compare.
    assign w_final      = nsc_merge(w_token[NUM_CELLS]);
    assign w_root_start = (r_state == ST_SCAN) && w_valid[NUM_CELLS];

    nsc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_final.best_d2),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_root_start) begin
            r_res_have <= w_final.have;
            r_res_idx  <= w_final.best_idx;
            r_res_x    <= w_final.best_x;
            r_res_y    <= w_final.best_y;
        end
    end

    // The output register may still hold an earlier result; it is reloaded
    // once that result has been taken or in the cycle it is taken.
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (w_cmd == CMD_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_valid[NUM_CELLS]) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= r_res_have;
            if (r_res_have) begin
                r_out_data <= {1'b0, w_root, r_res_y, r_res_x, r_res_idx};
            end else begin
                r_out_data <= {1'b0, DIST_NONE, {COORD_W{1'b0}}, {COORD_W{1'b0}},
                               {SLOT_W{1'b0}}};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_found;

    // Only one query token is ever inside the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) <= 1)
        else $error("more than one query token in the cell chain");

    // The token reaches the chain tail only while the control waits for it.
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[NUM_CELLS] |-> (r_state == ST_SCAN))
        else $error("query token left the chain outside the scan phase");

    // The root finishes only while the control waits for it.
    a_root_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == ST_ROOT))
        else $error("square root finished outside the root phase");

    // An empty search reports the all-ones distance.
    a_empty_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |->
            (r_out_data[OUT_DATA_W-2 -: DIST_W] == DIST_NONE))
        else $error("empty search without all-ones distance");

    // A found center lies within the largest reachable distance.
    a_found_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |->
            (r_out_data[OUT_DATA_W-2 -: DIST_W] <= DIST_W'(92681)))
        else $error("distance beyond the coordinate range");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest center search testbench
// Loads centers and sends queries over the input stream, mirrors the center
// table and the scan count, predicts the nearest center for every accepted
// query, and checks each result transfer against the oldest prediction while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import nsc_pkg::*;

    // Field positions inside the stream payloads, lowest field first.
    localparam int X_LSB     = SLOT_W;
    localparam int Y_LSB     = SLOT_W + COORD_W;
    localparam int D_LSB     = SLOT_W + 2 * COORD_W;
    localparam int IN_USED_W = SLOT_W + 2 * COORD_W;

    localparam int RANDOM_ITEMS   = 1500;
    // A trailing load leaves no result to wait for, so idle checks add this
    // margin before touching the register.
    localparam int DRAIN_CYCLES   = 120;
    localparam int LIMIT_CYCLES   = 3_000_000;
    localparam int HOLD_CYCLES    = 2000;
    localparam int FIRST_HOLD_AT  = 200;
    localparam int SECOND_HOLD_AT = 600;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIST_W-1:0]  distance;
    } t_match;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // center_slot, point_x, point_y
    logic                  s_axis_tuser = CMD_LOAD;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // nearest_slot, nearest_x, nearest_y, distance
    logic                  m_axis_tuser;   // found
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [COUNT_W-1:0]    i_cfg_data = '0;

    nearest_center_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock. Stimulus moves on the falling edge and everything is
    // sampled on the rising edge, so no check depends on event order.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Items waiting for the driver, and the predicted results in order.
    t_item  pending_items[$];
    t_match expected_matches[$];

    // Predictor state: a mirror of the center table and of centers_in_use.
    logic signed [COORD_W-1:0] center_x [NUM_CELLS];
    logic signed [COORD_W-1:0] center_y [NUM_CELLS];
    logic [COUNT_W-1:0]        scan_count = '0;

    // Cross-process counters. Each one has a single writer.
    int accepted_items = 0;   // input transfers seen by the monitor
    int queued_items   = 0;   // items handed to the driver by the generator
    int offered_items  = 0;   // items placed on the bus by the driver
    int results_seen   = 0;   // result transfers seen by the monitor
    int cfg_writes     = 0;   // register transfers seen by the monitor
    int error_cnt      = 0;
    int cycle_cnt      = 0;

    // Generator-side view of the table, used to aim queries at centers,
    // to build ties, and to never scan a slot that was never loaded.
    logic [COORD_W-1:0] gen_x [NUM_CELLS];
    logic [COORD_W-1:0] gen_y [NUM_CELLS];
    int                 gen_scan = 0;

    // Nearest center over the first scan_count entries, saturated at the
    // table size. Squared distances are compared exactly and only a strictly
    // smaller one wins, so ties keep the lower slot. The distance is the
    // integer square root rounded down, built one bit at a time.
    function automatic t_match nearest_center(input logic signed [COORD_W-1:0] qx,
                                              input logic signed [COORD_W-1:0] qy);
        t_match          m;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned best_d2;
        longint unsigned root;
        longint unsigned trial;
        int              n;
        int              i;
        int              b;
        m          = '0;
        m.distance = DIST_NONE;
        best_d2    = 0;
        n = (scan_count > NUM_CELLS) ? NUM_CELLS : int'(scan_count);
        for (i = 0; i < n; i++) begin
            dx = longint'(center_x[i]) - longint'(qx);
            dy = longint'(center_y[i]) - longint'(qy);
            d2 = longint'(dx * dx) + longint'(dy * dy);
            if (!m.found || d2 < best_d2) begin
                m.found = 1'b1;
                m.slot  = SLOT_W'(i);
                m.x     = center_x[i];
                m.y     = center_y[i];
                best_d2 = d2;
            end
        end
        if (m.found) begin
            root = 0;
            for (b = DIST_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= best_d2) begin
                    root = trial;
                end
            end
            m.distance = root[DIST_W-1:0];
        end
        return m;
    endfunction

    // Coordinates: a tight cluster around the origin (close calls and ties),
    // the corner values, or anything at all.
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0: begin
                v = COORD_W'($urandom_range(0, 15)) - COORD_W'(8);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = COORD_W'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic push_load(input int slot, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        t_item it;
        it.cmd  = CMD_LOAD;
        it.slot = SLOT_W'(slot);
        it.x    = x;
        it.y    = y;
        gen_x[slot] = x;
        gen_y[slot] = y;
        pending_items.insert(pending_items.size(), it);
        queued_items++;
    endtask

    // The slot field of a query is ignored by the block, so it is random.
    task automatic push_query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        t_item it;
        it.cmd  = CMD_QUERY;
        it.slot = SLOT_W'($urandom_range(0, NUM_CELLS - 1));
        it.x    = x;
        it.y    = y;
        pending_items.insert(pending_items.size(), it);
        queued_items++;
    endtask

    // Idle means every queued item was transferred and every predicted
    // result came back; the drain margin then covers a trailing load.
    task automatic wait_idle();
        while (accepted_items != queued_items || expected_matches.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_centers_in_use(input int value);
        int writes_before;
        wait_idle();
        writes_before = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= COUNT_W'(value);
        while (cfg_writes == writes_before) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        gen_scan = (value > NUM_CELLS) ? NUM_CELLS : value;
    endtask

    // Driver: presents one item at a time from the pending queue. It works
    // in bursts; after each burst it idles for a random gap, which is often
    // zero, sometimes short and sometimes longer than a whole query.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : driver
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (accepted_items == offered_items) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.cmd;
                s_axis_tdata  <= {{(IN_DATA_W - IN_USED_W){1'b0}}, nxt.y, nxt.x, nxt.slot};
                offered_items++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: gap_left = 0;
                        5, 6, 7:       gap_left = $urandom_range(1, 8);
                        default:       gap_left = $urandom_range(9, 120);
                    endcase
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns of random length. Twice it
    // holds off for a long stretch so that one result waits in the output
    // register, the next query completes behind it, and the input stalls.
    t_rx_mode rx_mode    = RX_ALWAYS;
    int       mode_left  = 0;
    int       hold_left  = 0;
    int       holds_done = 0;

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_done < 2 &&
                     results_seen >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default:   m_axis_tready <= !m_axis_tready;
            endcase
        end
    end

    // Monitor: on every rising edge it takes the register, input and result
    // transfers, keeps the predictor state current, and compares each result
    // field by field with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_match want;
        t_match got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                scan_count = i_cfg_data;
                cfg_writes <= cfg_writes + 1;
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.found    = m_axis_tuser;
                got.slot     = m_axis_tdata[0 +: SLOT_W];
                got.x        = m_axis_tdata[X_LSB +: COORD_W];
                got.y        = m_axis_tdata[Y_LSB +: COORD_W];
                got.distance = m_axis_tdata[D_LSB +: DIST_W];
                results_seen <= results_seen + 1;
                if (expected_matches.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("unexpected result: found=%0d slot=%0d x=%0d y=%0d dist=%0d",
                                 got.found, got.slot, $signed(got.x), $signed(got.y),
                                 got.distance);
                    end
                end else begin
                    want = expected_matches.pop_front();
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.x !== want.x || got.y !== want.y ||
                        got.distance !== want.distance) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $display("mismatch: expected found=%0d slot=%0d x=%0d y=%0d dist=%0d",
                                     want.found, want.slot, $signed(want.x),
                                     $signed(want.y), want.distance);
                            $display("          actual   found=%0d slot=%0d x=%0d y=%0d dist=%0d",
                                     got.found, got.slot, $signed(got.x),
                                     $signed(got.y), got.distance);
                        end
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                accepted_items <= accepted_items + 1;
                if (s_axis_tuser == CMD_LOAD) begin
                    center_x[s_axis_tdata[0 +: SLOT_W]] = s_axis_tdata[X_LSB +: COORD_W];
                    center_y[s_axis_tdata[0 +: SLOT_W]] = s_axis_tdata[Y_LSB +: COORD_W];
                end else begin
                    expected_matches.insert(expected_matches.size(),
                        nearest_center(s_axis_tdata[X_LSB +: COORD_W],
                                       s_axis_tdata[Y_LSB +: COORD_W]));
                end
            end
        end
    end

    // Watchdog for a block that hangs or drops results.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: a directed part, then random phases; each phase after the first
    // writes its own centers_in_use setting while the block is idle.
    initial begin : stimulus
        int slot_order[$];
        int random_items;
        int phase;
        int pick;
        int len;
        int k;
        int s;

        random_items = 0;
        phase        = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty scan right after reset: nothing found, distance all ones.
        push_query(16'h7FFF, 16'h8000);
        push_query(16'h0000, 16'h0000);

        // Corner centers and a duplicated pair to force a tie. Slot 63 is
        // loaded so that every slot bit is exercised.
        push_load(0, 16'h8000, 16'h8000);
        push_load(1, 16'h7FFF, 16'h7FFF);
        push_load(2, 16'd100, 16'hFF9C);    // (100, -100)
        push_load(3, 16'd100, 16'hFF9C);
        push_load(NUM_CELLS - 1, 16'hFFFF, 16'hFFFF);

        // One center, query at the opposite corner: the largest distance.
        write_centers_in_use(1);
        push_query(16'h7FFF, 16'h7FFF);

        write_centers_in_use(4);
        push_query(16'h7FFF, 16'h7FFF);     // exact hit on slot 1
        push_query(16'h8000, 16'h8000);     // exact hit on slot 0
        push_query(16'd100, 16'hFF9C);      // tie between slots 2 and 3
        push_query(16'h8000, 16'h7FFF);     // equal distance to slots 0 and 1
        push_query(16'h0000, 16'h0000);
        push_query(16'hFFFF, 16'hFFFF);

        // First random phase: fill the rest of the table in random order,
        // with queries over the entries already known to be loaded.
        for (s = 4; s < NUM_CELLS; s++) begin
            slot_order.insert(slot_order.size(), s);
        end
        while (slot_order.size() != 0) begin
            k = $urandom_range(0, slot_order.size() - 1);
            s = slot_order[k];
            slot_order.delete(k);
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(0, 3);
                push_load(s, gen_x[k], gen_y[k]);
            end else begin
                push_load(s, rand_coord(), rand_coord());
            end
            random_items++;
            if ($urandom_range(0, 1) == 0) begin
                push_query(rand_coord(), rand_coord());
                random_items++;
            end
        end

        // Later phases: the whole table is loaded, so any count is legal.
        // The extremes come first, including counts above the table size.
        while (random_items < RANDOM_ITEMS) begin
            case (phase)
                0:       pick = NUM_CELLS;
                1:       pick = (1 << COUNT_W) - 1;
                2:       pick = 0;
                3:       pick = NUM_CELLS + 1;
                4:       pick = 1;
                5:       pick = NUM_CELLS - 1;
                default: pick = ($urandom_range(0, 3) == 0) ?
                                $urandom_range(NUM_CELLS - 4, NUM_CELLS) :
                                $urandom_range(0, (1 << COUNT_W) - 1);
            endcase
            write_centers_in_use(pick);
            len = $urandom_range(40, 150);
            repeat (len) begin
                if ($urandom_range(0, 99) < 45) begin
                    s = $urandom_range(0, NUM_CELLS - 1);
                    if ($urandom_range(0, 4) == 0) begin
                        k = $urandom_range(0, NUM_CELLS - 1);
                        push_load(s, gen_x[k], gen_y[k]);
                    end else begin
                        push_load(s, rand_coord(), rand_coord());
                    end
                end else if (gen_scan > 0 && $urandom_range(0, 3) == 0) begin
                    // Land exactly on a scanned center: distance zero.
                    k = $urandom_range(0, gen_scan - 1);
                    push_query(gen_x[k], gen_y[k]);
                end else begin
                    push_query(rand_coord(), rand_coord());
                end
                random_items++;
            end
            phase++;
        end

        wait_idle();
        if (error_cnt == 0 && expected_matches.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
